// ===== rtl/mbcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbcs_pkg
// shared types, opcodes and tables of the bytecode channel sequencer
// ----------------------------------------------------------------------------
package mbcs_pkg;

    localparam int SONG_AW = 16;
    localparam int CHANNELS = 5;
    localparam int CH_W = 3;
    localparam int MAX_FETCH_STEPS = 96;
    localparam int STEP_W = 7;
    localparam int PC_W = 18;
    localparam int CFG_AW = 5;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] REG_LENGTH = 3'd0;
    localparam logic [2:0] REG_TRACK0 = 3'd1;

    localparam logic [7:0] BC_END = 8'h60;
    localparam logic [7:0] BC_END2 = 8'hFF;
    localparam logic [7:0] BC_REST = 8'hC8;
    localparam logic [7:0] BC_NOTE = 8'hC9;
    localparam logic [7:0] BC_SKIP2 = 8'hF1;
    localparam logic [7:0] BC_JUMP = 8'hF2;
    localparam logic [7:0] BC_SKIP_A = 8'hBC;
    localparam logic [7:0] BC_SKIP_B = 8'hE0;
    localparam logic [7:0] BC_SKIP_C = 8'hCC;
    localparam logic [7:0] BC_SKIP_D = 8'hCF;

    // command from the front part to the back part
    typedef struct packed {
        logic [1:0]      op;
        logic [CH_W-1:0] ch;
        logic [15:0]     addr;
        logic [7:0]      data;
    } t_cmd;

    typedef struct packed {
        logic       port;
        logic [7:0] addr;
        logic [7:0] data;
    } t_wr;

    function automatic logic [10:0] fnum(input logic [3:0] n);
        logic [10:0] f;
        unique case (n)
            4'd0: f = 11'h269;
            4'd1: f = 11'h28E;
            4'd2: f = 11'h2B4;
            4'd3: f = 11'h2DE;
            4'd4: f = 11'h30A;
            4'd5: f = 11'h338;
            4'd6: f = 11'h369;
            4'd7: f = 11'h39C;
            4'd8: f = 11'h3D3;
            4'd9: f = 11'h40E;
            4'd10: f = 11'h44B;
            default: f = 11'h48D;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] patch_row(input logic [2:0] r);
        logic [7:0] v;
        unique case (r)
            3'd0: v = 8'h31;
            3'd1: v = 8'h14;
            3'd2: v = 8'h1F;
            3'd5: v = 8'h05;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // write number k of the nine start writes
    function automatic t_wr init_wr(input logic [3:0] k);
        t_wr w;
        w.port = 1'b0;
        w.addr = 8'h28;
        unique case (k)
            4'd0: begin w.addr = 8'h29; w.data = 8'h80; end
            4'd1: begin w.addr = 8'h27; w.data = 8'h30; end
            4'd2: begin w.addr = 8'h07; w.data = 8'hB8; end
            4'd3: w.data = 8'd0;
            4'd4: w.data = 8'd1;
            4'd5: w.data = 8'd2;
            4'd6: w.data = 8'd4;
            4'd7: w.data = 8'd5;
            default: w.data = 8'd6;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mbcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbcs_front
// takes input beats and queues them as commands for the back part
// ----------------------------------------------------------------------------
module mbcs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mbcs_pkg::t_cmd i_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_take,
    output mbcs_pkg::t_cmd      o_cmd
);
    import mbcs_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop = o_cmd_valid && i_cmd_take;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mbcs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbcs_back
// song memory, channel state and bytecode interpreter; emits chip writes
// ----------------------------------------------------------------------------
module mbcs_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_take,
    input  wire mbcs_pkg::t_cmd         i_cmd,
    input  wire logic [16:0]            i_length,
    input  wire logic [5*16-1:0]        i_tracks,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_user,
    output logic [23:0]                 o_data,
    output logic                        o_last
);
    import mbcs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_DEC   = 9'b000001000,
        S_ARG   = 9'b000010000,
        S_NOTE  = 9'b000100000,
        S_KOFF  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_st, n_st;
    logic [7:0] r_mem [2**SONG_AW];
    logic [7:0] r_rd;
    logic [SONG_AW-1:0] rd_addr;

    logic [CHANNELS-1:0] r_en, r_fin;
    logic signed [PC_W-1:0] r_ptr [CHANNELS];
    logic [7:0] r_wait [CHANNELS];

    logic [CH_W-1:0] r_ch;
    logic signed [PC_W-1:0] r_pc;
    logic [STEP_W-1:0] r_steps;
    logic [7:0] r_b, r_a1;
    logic [1:0] r_argi;
    logic [4:0] r_k;
    logic [6:0] r_pitch;
    logic r_oval;
    t_wr r_ow;
    logic r_olast, r_owv;
    logic r_oce, r_oae;
    logic r_anyw;

    logic signed [PC_W-1:0] len_s;
    logic in_rng, in_rng1;
    logic [CH_W-1:0] ch;
    logic out_free;
    logic ext;
    logic [1:0] slot;
    logic [2:0] kid;
    logic [3:0] nt;
    logic [2:0] oct;
    logic [10:0] fn;
    logic [6:0] pm;

    assign ch = r_ch;
    assign len_s = $signed({1'b0, i_length});
    assign in_rng = (r_pc >= 0) && (r_pc < len_s);
    assign in_rng1 = (r_pc + 18'sd1 < len_s);
    assign out_free = !r_oval || i_ready;
    assign rd_addr = r_pc[SONG_AW-1:0];
    assign ext = (ch >= CH_W'(3));
    assign slot = ext ? 2'(ch - CH_W'(3)) : ch[1:0];
    assign kid = ext ? ch + CH_W'(1) : ch;
    // pitch split: octave by small compare chain
    always_comb begin
        pm = r_pitch;
        oct = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (pm >= 7'd12) begin
                pm = pm - 7'd12;
                oct = oct + 3'd1;
            end
        end
        nt = pm[3:0];
        fn = fnum(nt);
    end

    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid;
    assign o_valid = r_oval;
    assign o_last = r_olast;

    logic all_end, ch_end;
    always_comb begin
        all_end = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_en[i] && !r_fin[i]) all_end = 1'b0;
        end
        ch_end = (ch < CH_W'(CHANNELS)) ? r_fin[ch] : 1'b0;
    end
    // status flags are captured with the beat so a held beat stays stable
    assign o_user = r_owv;
    assign o_data = {5'd0, r_oae, r_oce, r_ow.data, r_ow.addr, r_ow.port};

    // emit helper signals
    logic emit;
    t_wr ew;
    logic elast, ewv;

    always_comb begin
        emit = 1'b0;
        ew = '0;
        elast = 1'b0;
        ewv = 1'b1;
        n_st = r_st;
        unique case (r_st)
            S_INIT: begin
                emit = out_free;
                ew = init_wr(r_k[3:0]);
                elast = (r_k == 5'd8);
            end
            S_NOTE: begin
                emit = out_free;
                ew.port = ext;
                if (r_k < 5'd24) begin
                    ew.addr = 8'h30 + {6'd0, slot} + {4'd0, r_k[1:0], 2'd0}
                        + {1'b0, r_k[4:2], 4'd0};
                    ew.data = patch_row(r_k[4:2]);
                end else begin
                    unique case (r_k)
                        5'd24: begin ew.addr = 8'hB0 + {6'd0, slot}; ew.data = 8'h3C; end
                        5'd25: begin ew.addr = 8'hB4 + {6'd0, slot}; ew.data = 8'hC0; end
                        5'd26: begin
                            ew.addr = 8'hA4 + {6'd0, slot};
                            ew.data = {2'd0, oct, fn[10:8]};
                        end
                        5'd27: begin ew.addr = 8'hA0 + {6'd0, slot}; ew.data = fn[7:0]; end
                        default: begin
                            ew.port = 1'b0;
                            ew.addr = 8'h28;
                            ew.data = {5'h1E, kid};
                        end
                    endcase
                end
                elast = (r_k == 5'd28);
            end
            S_KOFF: begin
                emit = out_free;
                ew.addr = 8'h28;
                ew.data = {5'd0, kid};
                elast = 1'b1;
            end
            S_FIN: begin
                emit = out_free && !r_anyw;
                ewv = 1'b0;
                elast = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (r_st == S_IDLE && i_cmd_valid && i_cmd.op == OP_LOAD) begin
            r_mem[i_cmd.addr] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_en <= '0;
            r_fin <= '0;
            r_oval <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_ptr[i] <= '0;
                r_wait[i] <= '0;
            end
        end else begin
            r_oval <= emit || (r_oval && !i_ready);
            if (emit) begin
                r_ow <= ew;
                r_owv <= ewv;
                r_olast <= elast;
                r_oce <= ch_end;
                r_oae <= all_end;
                r_anyw <= 1'b1;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_ch <= i_cmd.ch;
                        r_anyw <= 1'b0;
                        r_k <= '0;
                        r_st <= S_FIN;
                        if (i_cmd.op == OP_START) begin
                            for (int i = 0; i < CHANNELS; i++) begin
                                logic [15:0] t;
                                logic on;
                                t = i_tracks[i*16 +: 16];
                                on = (t != 16'd0) && ({1'b0, t} < i_length);
                                r_en[i] <= on;
                                r_fin[i] <= 1'b0;
                                r_ptr[i] <= on ? PC_W'(t) : '0;
                                r_wait[i] <= on ? 8'd1 : 8'd0;
                            end
                            r_st <= S_INIT;
                        end else if (i_cmd.op == OP_TICK && i_cmd.ch < CH_W'(CHANNELS)
                                && r_en[i_cmd.ch] && !r_fin[i_cmd.ch]) begin
                            if (r_wait[i_cmd.ch] > 8'd1) begin
                                r_wait[i_cmd.ch] <= r_wait[i_cmd.ch] - 8'd1;
                            end else begin
                                r_wait[i_cmd.ch] <= 8'd0;
                                r_pc <= r_ptr[i_cmd.ch];
                                r_steps <= '0;
                                r_st <= S_RD;
                            end
                        end
                    end
                end
                S_INIT: begin
                    if (emit) begin
                        r_k <= r_k + 5'd1;
                        if (elast) r_st <= S_IDLE;
                    end
                end
                S_RD: begin
                    // fetch loop head
                    if (r_steps == STEP_W'(MAX_FETCH_STEPS)) begin
                        r_wait[ch] <= 8'd1;
                        r_ptr[ch] <= r_pc;
                        r_st <= S_FIN;
                    end else if (!in_rng) begin
                        r_fin[ch] <= 1'b1;
                        r_ptr[ch] <= r_pc;
                        r_st <= S_FIN;
                    end else begin
                        r_steps <= r_steps + STEP_W'(1);
                        r_pc <= r_pc + 18'sd1;
                        r_st <= S_DEC;
                    end
                end
                S_DEC: begin
                    // r_rd holds the opcode, r_pc points after it
                    r_b <= r_rd;
                    r_argi <= '0;
                    if (r_rd == BC_END || r_rd == BC_END2) begin
                        r_fin[ch] <= 1'b1;
                        r_ptr[ch] <= r_pc;
                        r_st <= S_KOFF;
                    end else if (r_rd == BC_SKIP2) begin
                        if (in_rng1) r_pc <= r_pc + 18'sd2;
                        r_st <= S_RD;
                    end else if (r_rd == BC_SKIP_B || r_rd == BC_SKIP_C
                            || r_rd == BC_SKIP_D) begin
                        // the bare pitch range wins over the one-byte skip code in it
                        if (in_rng) r_pc <= r_pc + 18'sd1;
                        r_st <= S_RD;
                    end else if (r_rd == BC_JUMP && !in_rng) begin
                        r_fin[ch] <= 1'b1;
                        r_ptr[ch] <= r_pc;
                        r_st <= S_FIN;
                    end else if (r_rd >= 8'h80) begin
                        r_st <= S_ARG;
                    end else begin
                        r_st <= S_RD;
                    end
                end
                S_ARG: begin
                    // r_rd holds byte at r_pc (valid only if in range)
                    if (r_b == BC_NOTE) begin
                        if (r_argi == 2'd0) begin
                            r_a1 <= in_rng ? r_rd : 8'hA0;
                            if (in_rng) r_pc <= r_pc + 18'sd1;
                            r_argi <= 2'd1;
                            r_st <= S_ARG;
                        end else if (r_argi == 2'd1) begin
                            // wait for the registered read of the second byte
                            r_argi <= 2'd2;
                        end else begin
                            logic [7:0] d;
                            logic [6:0] p7;
                            d = in_rng ? r_rd : 8'd8;
                            if (in_rng) r_pc <= r_pc + 18'sd1;
                            r_wait[ch] <= (d == 8'd0) ? 8'd1 : d;
                            if (r_a1 >= 8'hA0 && r_a1 <= 8'hBF) begin
                                r_pitch <= 7'(r_a1 - 8'hA0) + 7'd48;
                            end else begin
                                p7 = r_a1[6:0];
                                r_pitch <= (p7 >= 7'd84) ? p7 - 7'd84 : p7;
                            end
                            r_ptr[ch] <= in_rng ? r_pc + 18'sd1 : r_pc;
                            r_k <= '0;
                            r_st <= S_NOTE;
                        end
                    end else if (r_b == BC_REST) begin
                        logic [7:0] w;
                        w = in_rng ? r_rd : 8'd8;
                        r_wait[ch] <= (w == 8'd0) ? 8'd1 : w;
                        r_ptr[ch] <= in_rng ? r_pc + 18'sd1 : r_pc;
                        r_st <= S_KOFF;
                    end else if (r_b == BC_JUMP) begin
                        r_pc <= r_pc + 18'sd1 + PC_W'($signed(r_rd));
                        r_st <= S_RD;
                    end else if (r_b >= 8'hA0 && r_b <= 8'hBF) begin
                        logic tk;
                        tk = in_rng && r_rd < 8'h80;
                        r_wait[ch] <= !tk ? 8'd8 : (r_rd == 8'd0 ? 8'd1 : r_rd);
                        r_ptr[ch] <= tk ? r_pc + 18'sd1 : r_pc;
                        r_pitch <= 7'(r_b - 8'hA0) + 7'd48;
                        r_k <= '0;
                        r_st <= S_NOTE;
                    end else begin
                        if (in_rng && r_rd < 8'h80) r_pc <= r_pc + 18'sd1;
                        r_st <= S_RD;
                    end
                end
                S_NOTE: begin
                    if (emit) begin
                        r_k <= r_k + 5'd1;
                        if (elast) r_st <= S_IDLE;
                    end
                end
                S_KOFF: begin
                    if (emit) r_st <= S_IDLE;
                end
                S_FIN: begin
                    if (r_anyw) r_st <= S_IDLE;
                    else if (emit) r_st <= S_OUT;
                end
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/music_bytecode_channel_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// music_bytecode_channel_sequencer_unit
// five-channel music bytecode interpreter producing fm chip register writes
// ----------------------------------------------------------------------------
// A start sends 9 write beats. A tick that fetches walks the song memory
// byte by byte (one registered memory read port), up to 96 opcodes, then
// sends 29 write beats for a note or one for a rest or end. Every beat out is
// one chip write; items without a write give one beat with write_valid low.
// A two-entry command queue decouples input from the interpreter.
module music_bytecode_channel_sequencer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tuser: operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // tdata: channel[2:0], address[18:3], data[26:19]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tuser: write_valid[0]
    output logic             m_axis_tuser,
    // tdata: port_high[0], reg_address[8:1], reg_data[16:9],
    //        channel_ended[17], all_ended[18]
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbcs_pkg::*;

    logic [16:0] r_len;
    logic [15:0] r_trk [5];
    logic [5*16-1:0] trks;
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_take;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int i = 0; i < 5; i++) r_trk[i] <= '0;
        end else if (psel && penable && pwrite) begin
            if (ridx == REG_LENGTH) r_len <= pwdata[16:0];
            else if (ridx >= REG_TRACK0 && ridx <= 3'd5) r_trk[ridx - 3'd1] <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (ridx == REG_LENGTH) prdata = {15'd0, r_len};
        else if (ridx >= REG_TRACK0 && ridx <= 3'd5) prdata = {16'd0, r_trk[ridx - 3'd1]};
        for (int i = 0; i < 5; i++) trks[i*16 +: 16] = r_trk[i];
    end

    assign in_cmd.op = s_axis_tuser;
    assign in_cmd.ch = s_axis_tdata[2:0];
    assign in_cmd.addr = s_axis_tdata[18:3];
    assign in_cmd.data = s_axis_tdata[26:19];

    mbcs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_cmd_valid(q_valid), .i_cmd_take(q_take), .o_cmd(q_cmd)
    );

    mbcs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(q_valid), .o_cmd_take(q_take), .i_cmd(q_cmd),
        .i_length(r_len), .i_tracks(trks),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_user(m_axis_tuser), .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== rtl/mbcs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbcs_checker
// port-level checks of the sequencer unit
// ----------------------------------------------------------------------------
module mbcs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic        m_axis_tuser,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        pready
);
    // a beat without a write is always the only one of its item
    a_nowr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("no-write beat without last");
    a_nowr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[16:0] == 17'd0)
        else $error("no-write beat with payload");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled beat changed");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind music_bytecode_channel_sequencer_unit mbcs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .pready(pready)
);
`default_nettype wire

// ===== tb/music_bytecode_channel_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// music_bytecode_channel_sequencer_unit_tb
// self-checking bench: loads song bytes, configures tracks over apb, starts
// playback and ticks channels, and checks every chip write beat against an
// in-bench interpreter of the bytecode
// ----------------------------------------------------------------------------
module music_bytecode_channel_sequencer_unit_tb;
    import mbcs_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int STORE = 65536;

    typedef struct packed {
        bit       wv;
        bit       port;
        bit [7:0] ra;
        bit [7:0] rd;
        bit       last;
        bit       ce;
        bit       ae;
    } chip_beat_t;

    typedef struct {
        logic [1:0] op;
        logic [2:0] ch;
        logic [15:0] addr;
        logic [7:0] data;
        bit typed;
        bit ce;
        bit ae;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [1:0] s_tuser = '0;
    logic [31:0] s_tdata = '0;
    logic m_tready = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire s_axis_tready, m_axis_tvalid, m_axis_tlast, m_axis_tuser, pready;
    wire [23:0] m_axis_tdata;
    wire [31:0] prdata;

    music_bytecode_channel_sequencer_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_tuser), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_tready),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // interpreter state
    logic [7:0] song_mem [0:STORE-1];
    int  len_reg;
    int  trk_reg [5];
    bit  ch_on [5];
    bit  ch_done [5];
    int  ch_pc [5];
    int  ch_wait [5];
    chip_beat_t item_wr[$];
    chip_beat_t chip_wr_q[$];

    int  errs = 0;
    int  cyc = 0;
    int  tx_p = 0;
    int  rx_p = 0;
    int  hold_cnt = 0;

    const bit [10:0] fnum_tab [12] = '{11'h269, 11'h28E, 11'h2B4, 11'h2DE, 11'h30A,
        11'h338, 11'h369, 11'h39C, 11'h3D3, 11'h40E, 11'h44B, 11'h48D};
    const bit [7:0] patch_tab [6] = '{8'h31, 8'h14, 8'h1F, 8'h00, 8'h00, 8'h05};

    function automatic void chip_wr(bit p, int a, int d);
        chip_beat_t b;
        b = '0;
        b.wv = 1'b1;
        b.port = p;
        b.ra = a[7:0];
        b.rd = d[7:0];
        item_wr.push_back(b);
    endfunction

    function automatic int key_code(int c);
        return c >= 3 ? c + 1 : c;
    endfunction

    function automatic void note_on(int c, int pitch);
        bit ext;
        int slot, oct, fn;
        ext = c >= 3;
        slot = ext ? c - 3 : c;
        oct = pitch / 12;
        if (oct > 7) oct = 7;
        fn = fnum_tab[pitch % 12];
        for (int i = 0; i < 24; i++)
            chip_wr(ext, 8'h30 + slot + (i % 4) * 4 + (i / 4) * 16, patch_tab[i / 4]);
        chip_wr(ext, 8'hB0 + slot, 8'h3C);
        chip_wr(ext, 8'hB4 + slot, 8'hC0);
        chip_wr(ext, 8'hA4 + slot, ((oct << 3) & 8'h38) | ((fn >> 8) & 7));
        chip_wr(ext, 8'hA0 + slot, fn & 8'hFF);
        chip_wr(0, 8'h28, 8'hF0 | key_code(c));
    endfunction

    // walk bytecode until a note/rest/end or the step budget runs out
    function automatic bit fetch_ops(int c);
        int n, pc, steps, nxt, b, w, p, d, r;
        bit got;
        n = len_reg < STORE ? len_reg : STORE;
        pc = ch_pc[c];
        got = 0;
        steps = 0;
        while (ch_on[c] && !ch_done[c] && steps < MAX_FETCH_STEPS) begin
            steps++;
            if (pc < 0 || pc >= n) begin
                ch_done[c] = 1;
                break;
            end
            b = song_mem[pc];
            pc++;
            nxt = pc < n ? int'(song_mem[pc]) : -1;
            if (b == BC_END || b == BC_END2) begin
                ch_done[c] = 1;
                chip_wr(0, 8'h28, key_code(c));
                break;
            end
            if (b == BC_REST) begin
                w = 8;
                if (nxt >= 0) begin
                    w = song_mem[pc];
                    pc++;
                end
                ch_wait[c] = w < 1 ? 1 : w;
                chip_wr(0, 8'h28, key_code(c));
                got = 1;
                break;
            end
            if (b == BC_NOTE) begin
                p = 8'hA0;
                d = 8;
                if (pc < n) begin p = song_mem[pc]; pc++; end
                if (pc < n) begin d = song_mem[pc]; pc++; end
                ch_wait[c] = d < 1 ? 1 : d;
                if (p >= 8'hA0 && p <= 8'hBF) note_on(c, p - 8'hA0 + 48);
                else note_on(c, (p & 8'h7F) % 84);
                got = 1;
                break;
            end
            if (b >= 8'hA0 && b <= 8'hBF) begin
                d = 8;
                if (nxt >= 0 && nxt < 8'h80) begin
                    d = song_mem[pc];
                    pc++;
                    if (d < 1) d = 1;
                end
                ch_wait[c] = d;
                note_on(c, b - 8'hA0 + 48);
                got = 1;
                break;
            end
            if (b == BC_SKIP2) begin
                if (pc + 1 < n) pc += 2;
                continue;
            end
            if (b == BC_JUMP) begin
                if (pc >= n) begin
                    ch_done[c] = 1;
                    break;
                end
                r = song_mem[pc];
                pc++;
                pc += r - (r >= 8'h80 ? 256 : 0);
                continue;
            end
            if (b == BC_SKIP_A || b == BC_SKIP_B || b == BC_SKIP_C || b == BC_SKIP_D) begin
                if (pc < n) pc++;
                continue;
            end
            if (b >= 8'h80 && nxt >= 0 && nxt < 8'h80) pc++;
        end
        ch_pc[c] = pc;
        return got;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [2:0] ch,
                                         logic [15:0] addr, logic [7:0] data);
        chip_beat_t z;
        bit ce, ae;
        item_wr.delete();
        if (op == OP_LOAD) begin
            song_mem[addr] = data;
        end else if (op == OP_START) begin
            for (int i = 0; i < 5; i++) begin
                ch_on[i] = trk_reg[i] > 0 && trk_reg[i] < len_reg;
                ch_done[i] = 0;
                ch_pc[i] = ch_on[i] ? trk_reg[i] : 0;
                ch_wait[i] = ch_on[i] ? 1 : 0;
            end
            chip_wr(0, 8'h29, 8'h80);
            chip_wr(0, 8'h27, 8'h30);
            chip_wr(0, 8'h07, 8'hB8);
            for (int i = 0; i < 7; i++)
                if (i != 3) chip_wr(0, 8'h28, i);
        end else if (op == OP_TICK && ch < 5) begin
            if (ch_on[ch] && !ch_done[ch]) begin
                if (ch_wait[ch] > 1) begin
                    ch_wait[ch]--;
                end else begin
                    ch_wait[ch] = 0;
                    if (!fetch_ops(ch) && !ch_done[ch]) ch_wait[ch] = 1;
                end
            end
        end
        if (item_wr.size() == 0) begin
            z = '0;
            item_wr.push_back(z);
        end
        ce = ch < 5 && ch_done[ch];
        ae = 1;
        for (int i = 0; i < 5; i++)
            if (ch_on[i] && !ch_done[i]) ae = 0;
        foreach (item_wr[k]) begin
            item_wr[k].ce = ce;
            item_wr[k].ae = ae;
            item_wr[k].last = (k == item_wr.size() - 1);
            chip_wr_q.push_back(item_wr[k]);
        end
    endfunction

    // one input beat; returns after acceptance, then maybe idles
    task automatic send_item(logic [1:0] op, logic [2:0] ch, logic [15:0] addr,
                             logic [7:0] data, bit typed = 0, bit ce = 0, bit ae = 0);
        chip_beat_t t;
        int n;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, data, addr, ch};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (typed) begin
            n = chip_wr_q.size();
            predict_item(op, ch, addr, data);
            while (chip_wr_q.size() > n) void'(chip_wr_q.pop_back());
            t = '0;
            t.last = 1;
            t.ce = ce;
            t.ae = ae;
            chip_wr_q.push_back(t);
        end else begin
            predict_item(op, ch, addr, data);
        end
        if ($urandom_range(0, 99) < tx_p) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (chip_wr_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(int idx, int val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LENGTH) len_reg = val & 32'h1FFFF;
        else trk_reg[idx - REG_TRACK0] = val & 32'hFFFF;
    endtask

    task automatic set_tracks(int len, int t0, int t1, int t2, int t3, int t4);
        reg_write(REG_LENGTH, len);
        reg_write(REG_TRACK0, t0);
        reg_write(REG_TRACK0 + 1, t1);
        reg_write(REG_TRACK0 + 2, t2);
        reg_write(REG_TRACK0 + 3, t3);
        reg_write(REG_TRACK0 + 4, t4);
    endtask

    // fill [0, len) with mostly well-formed bytecode
    task automatic write_song(int len, bit filler);
        logic [7:0] seq[$];
        int a, k;
        a = 0;
        while (a < len) begin
            seq.delete();
            k = $urandom_range(0, 15);
            if (filler) seq.push_back(a == len - 1 ? BC_END : 8'h12);
            else if (k == 0) seq = '{BC_NOTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 5))};
            else if (k == 1) seq = '{BC_REST, 8'($urandom_range(0, 4))};
            else if (k == 2) seq = '{BC_SKIP2, 8'($urandom), 8'($urandom)};
            else if (k == 3) seq = '{BC_JUMP, 8'($urandom_range(0, 255))};
            else if (k == 4) seq = '{BC_SKIP_B, 8'($urandom)};
            else if (k == 5) seq = '{BC_SKIP_C, 8'($urandom)};
            else if (k == 6) seq = '{BC_SKIP_D, 8'($urandom)};
            else if (k == 7) seq = '{BC_SKIP_A, 8'($urandom)};
            else if (k == 8) seq = '{8'($urandom_range(8'h80, 8'hFE)), 8'($urandom_range(0, 8'h7F))};
            else if (k == 9) seq = '{8'($urandom_range(0, 8'h5F))};
            else if (k == 10) seq = '{$urandom_range(0, 1) ? BC_END : BC_END2};
            else if (k < 13) seq = '{8'($urandom_range(8'hA0, 8'hBF))};
            else seq = '{8'($urandom_range(8'hA0, 8'hBF)), 8'($urandom_range(0, 6))};
            foreach (seq[j])
                if (a < len) begin
                    send_item(OP_LOAD, 3'($urandom), 16'(a), seq[j]);
                    a++;
                end
        end
    endtask

    task automatic random_items(int cnt);
        int r;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_item(OP_TICK, 3'($urandom_range(0, 4)), 16'($urandom), 8'($urandom));
            else if (r < 76) send_item(OP_TICK, 3'($urandom_range(5, 7)), 16'($urandom),
                                       8'($urandom));
            else if (r < 80) send_item(2'd3, 3'($urandom), 16'($urandom), 8'($urandom));
            else if (r < 86) send_item(OP_LOAD, 3'($urandom),
                                       16'($urandom_range(len_reg, 65535)), 8'($urandom));
            else if (r < 90) send_item(OP_START, 3'($urandom), 16'($urandom), 8'($urandom));
            else send_item(OP_TICK, 3'($urandom_range(0, 4)), 16'($urandom), 8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= rx_p;
        end
    end

    always @(posedge i_clk) begin
        chip_beat_t got, want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            got.wv = m_axis_tuser;
            got.port = m_axis_tdata[0];
            got.ra = m_axis_tdata[8:1];
            got.rd = m_axis_tdata[16:9];
            got.ce = m_axis_tdata[17];
            got.ae = m_axis_tdata[18];
            got.last = m_axis_tlast;
            if (chip_wr_q.size() == 0) begin
                $error("unexpected beat %h", got);
                errs++;
            end else begin
                want = chip_wr_q.pop_front();
                if (got.wv != want.wv) begin
                    $error("write_valid exp %0d got %0d", want.wv, got.wv); errs++;
                end
                if (got.port != want.port) begin
                    $error("port_high exp %0d got %0d", want.port, got.port); errs++;
                end
                if (got.ra != want.ra) begin
                    $error("reg_address exp %0h got %0h", want.ra, got.ra); errs++;
                end
                if (got.rd != want.rd) begin
                    $error("reg_data exp %0h got %0h", want.rd, got.rd); errs++;
                end
                if (got.last != want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errs++;
                end
                if (got.ce != want.ce) begin
                    $error("channel_ended exp %0d got %0d", want.ce, got.ce); errs++;
                end
                if (got.ae != want.ae) begin
                    $error("all_ended exp %0d got %0d", want.ae, got.ae); errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // small song with note, rest, skip, jump and end opcodes; tracks at 1, 4, 9, 21, 23
    const logic [7:0] demo_song [24] = '{8'h00, 8'hC9, 8'h30, 8'h02, 8'hA5, 8'h03,
        8'hA0, 8'hC8, 8'h00, 8'hF1, 8'h11, 8'h22, 8'hBC, 8'h07, 8'h85, 8'h10,
        8'h12, 8'hF2, 8'h02, 8'hFF, 8'h60, 8'hBF, 8'h01, 8'h60};

    dir_row_t dir_tab [$];

    initial begin
        int len;
        len_reg = 0;
        foreach (trk_reg[i]) begin
            trk_reg[i] = 0; ch_on[i] = 0; ch_done[i] = 0; ch_pc[i] = 0; ch_wait[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle after reset: no track enabled, all channels count as ended
        dir_tab.push_back('{OP_TICK, 3'd0, 16'h0000, 8'h00, 1, 0, 1});
        dir_tab.push_back('{2'd3, 3'd7, 16'hFFFF, 8'hFF, 1, 0, 1});
        dir_tab.push_back('{OP_TICK, 3'd7, 16'hFFFF, 8'hFF, 1, 0, 1});
        dir_tab.push_back('{OP_START, 3'd5, 16'h0000, 8'h00, 0, 0, 0});
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].addr, dir_tab[i].data,
                      dir_tab[i].typed, dir_tab[i].ce, dir_tab[i].ae);
        wait_drain();

        set_tracks(24, 1, 4, 9, 21, 23);
        foreach (demo_song[i]) send_item(OP_LOAD, 3'd0, 16'(i), demo_song[i]);
        dir_tab.delete();
        dir_tab.push_back('{OP_START, 3'd0, 16'h0, 8'h0, 0, 0, 0});
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 5; c++)
                dir_tab.push_back('{OP_TICK, 3'(c), 16'h0, 8'h0, 0, 0, 0});
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].addr, dir_tab[i].data);
        random_items(20);
        wait_drain();

        // store end: rest at the last byte, end far in, three tracks at the limit
        set_tracks(65536, 65535, 40000, 65535, 0, 65535);
        send_item(OP_LOAD, 3'd1, 16'hFFFF, BC_REST);
        send_item(OP_LOAD, 3'd2, 16'd40000, BC_END);
        send_item(OP_START, 3'd0, 16'h0, 8'h0);
        for (int i = 0; i < 12; i++) send_item(OP_TICK, 3'(i % 5), 16'h0, 8'h0);
        wait_drain();

        for (int ph = 0; ph < 8; ph++) begin
            tx_p = (ph % 4 == 1) ? 58 : (ph % 4 == 3) ? 28 : 0;
            rx_p = (ph % 4 == 2) ? 58 : (ph % 4 == 3) ? 28 : 0;
            len = (ph == 5) ? 100 : (ph == 7) ? $urandom_range(0, 1) : $urandom_range(4, 16);
            if (ph == 6) set_tracks(65535, 65535, 0, 0, 0, 0);
            else set_tracks(len, $urandom_range(0, len + 2), $urandom_range(1, len),
                            $urandom_range(0, len), $urandom_range(1, len + 2),
                            $urandom_range(0, len));
            write_song(ph == 6 ? 0 : len, ph == 5);
            send_item(OP_START, 3'($urandom), 16'($urandom), 8'($urandom));
            if (ph == 2) hold_cnt = 400;
            random_items(8);
            wait_drain();
        end

        if (errs == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
